// ===== src/meter_response_frame_checker_macros.svh =====
// ---------------------------------------------------------------------------
// meter response frame checker assertion macros
// shared assertion shorthands for the frame checker rtl
// ---------------------------------------------------------------------------
`ifndef METER_RESPONSE_FRAME_CHECKER_MACROS_SVH
`define METER_RESPONSE_FRAME_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MRFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MRFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mrfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrfc_pkg
// types, constants and the crc-16/modbus byte update for the frame checker
// ---------------------------------------------------------------------------
package mrfc_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_CRC   = 3'd2,
    VERDICT_BAD_ADDR  = 3'd3,
    VERDICT_DEV_ERROR = 3'd4,
    VERDICT_OVERLEN   = 3'd5
  } verdict_e;

  localparam logic [0:0] REG_EXPECTED_ADDRESS = 1'b0;
  localparam logic [0:0] REG_SKIP_CRC_CHECK   = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [5:0] COUNT_LIMIT = 6'd63;
  localparam logic [5:0] MIN_FRAME   = 6'd4;
  localparam logic [5:0] HDR_BYTES   = 6'd3;
  localparam logic [3:0] STATUS_MASK = 4'hF;

  // one byte through the reflected crc, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/meter_response_frame_checker.sv =====
`timescale 1ns / 1ps
// the frame-end beat passes the input register, then the result register, which
// loads with out_valid once the output is free; crc update is one byte-wide xor net
// throughput: one byte beat per cycle while no verdict is stalled at the output
// reset: frame state returns to crc 0xffff and zero counts and bytes,
// expected_address and skip_crc_check clear to 0, no verdict pending
// ---------------------------------------------------------------------------
// meter response frame checker
// checks crc, address and status of a received reply frame, one byte a beat
// ---------------------------------------------------------------------------
`include "meter_response_frame_checker_macros.svh"

module meter_response_frame_checker
  import mrfc_pkg::*;
#(
  parameter int MAX_FRAME = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  // verdict output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [4:0]  payload_length_o,
  output logic [15:0] received_crc_o
);

  localparam logic [5:0] MaxFrame = 6'(MAX_FRAME);

  // configuration registers
  logic [7:0] exp_addr_q;
  logic       skip_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= 8'h00;
      skip_crc_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EXPECTED_ADDRESS: exp_addr_q <= cfg_wdata_i;
        REG_SKIP_CRC_CHECK:   skip_crc_q <= cfg_wdata_i[0];
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       out_valid_q;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!s1_end_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
      s1_end_q  <= frame_end_i;
    end
  end

  // frame state
  logic [15:0] crc_q, crc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  second_q, second_d;
  logic [7:0]  older_q, older_d;
  logic [7:0]  newer_q, newer_d;
  logic        ovl_q, ovl_d;

  always_comb begin
    crc_d    = (cnt_q >= 6'd2) ? crc_feed(crc_q, older_q) : crc_q;
    first_d  = (cnt_q == 6'd0) ? s1_byte_q : first_q;
    second_d = (cnt_q == 6'd1) ? s1_byte_q : second_q;
    older_d  = newer_q;
    newer_d  = s1_byte_q;
    cnt_d    = (cnt_q != COUNT_LIMIT) ? cnt_q + 6'd1 : cnt_q;
    ovl_d    = ovl_q || (cnt_d > MaxFrame);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      cnt_q    <= 6'd0;
      first_q  <= 8'h00;
      second_q <= 8'h00;
      older_q  <= 8'h00;
      newer_q  <= 8'h00;
      ovl_q    <= 1'b0;
    end else if (s1_fire) begin
      if (s1_end_q) begin
        crc_q    <= CRC_INIT;
        cnt_q    <= 6'd0;
        first_q  <= 8'h00;
        second_q <= 8'h00;
        older_q  <= 8'h00;
        newer_q  <= 8'h00;
        ovl_q    <= 1'b0;
      end else begin
        crc_q    <= crc_d;
        cnt_q    <= cnt_d;
        first_q  <= first_d;
        second_q <= second_d;
        older_q  <= older_d;
        newer_q  <= newer_d;
        ovl_q    <= ovl_d;
      end
    end
  end

  // verdict for the frame that ends on this beat
  verdict_e    verdict_d;
  logic [4:0]  plen_d;
  logic [15:0] rcrc_d;
  logic [15:0] rcrc;
  logic [15:0] calc;
  logic [5:0]  plen_full;

  assign rcrc      = {older_d, newer_d};
  // crc goes out low byte first, so swap before comparing
  assign calc      = {crc_d[7:0], crc_d[15:8]};
  assign plen_full = cnt_d - HDR_BYTES;

  always_comb begin
    plen_d = plen_full[4:0];
    rcrc_d = rcrc;
    if (ovl_d) begin
      verdict_d = VERDICT_OVERLEN;
      plen_d    = 5'd0;
    end else if (cnt_d < MIN_FRAME) begin
      verdict_d = VERDICT_SHORT;
      plen_d    = 5'd0;
      rcrc_d    = 16'h0000;
    end else if (!skip_crc_q && (rcrc != calc)) begin
      verdict_d = VERDICT_BAD_CRC;
    end else if (first_d != exp_addr_q) begin
      verdict_d = VERDICT_BAD_ADDR;
    end else if ((cnt_d == MIN_FRAME) && ((second_d[3:0] & STATUS_MASK) != 4'h0)) begin
      verdict_d = VERDICT_DEV_ERROR;
    end else begin
      verdict_d = VERDICT_OK;
    end
  end

  // result register
  verdict_e    verdict_q;
  logic [4:0]  plen_q;
  logic [15:0] rcrc_q;
  logic        res_load;

  assign res_load = s1_fire && s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= res_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      verdict_q <= verdict_d;
      plen_q    <= plen_d;
      rcrc_q    <= rcrc_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign payload_length_o = plen_q;
  assign received_crc_o   = rcrc_q;

  `MRFC_ASSERT_NEXT(a_frame_clears, clk_i, rst_ni, res_load, (cnt_q == 6'd0) && !ovl_q && (crc_q == CRC_INIT), "frame state not cleared after frame end")
  `MRFC_ASSERT_NOW(a_ovl_count, clk_i, rst_ni, ovl_q, cnt_q > MaxFrame, "overlength flag without overlength count")
  `MRFC_ASSERT_NOW(a_short_zero, clk_i, rst_ni, out_valid_q && (verdict_q == VERDICT_SHORT), (plen_q == 5'd0) && (rcrc_q == 16'h0000), "short frame verdict with nonzero fields")
  `MRFC_ASSERT_NOW(a_ovl_plen, clk_i, rst_ni, out_valid_q && (verdict_q == VERDICT_OVERLEN), plen_q == 5'd0, "overlength verdict with nonzero length")
  `MRFC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !res_load, "verdict loaded over a stalled verdict")

endmodule

// ===== dv/meter_response_frame_checker_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// meter response frame checker testbench
// feeds reply frames byte by byte through a valid/ready driver, predicts the
// frame verdict, payload length and received crc for every frame-end beat,
// and compares each verdict beat against the oldest prediction. runs through
// several address and crc-skip settings with random gaps and stalls.
// ---------------------------------------------------------------------------

module meter_response_frame_checker_tb
  import mrfc_pkg::*;
;

  localparam int FRAME_MAX  = 32;
  localparam int RUN_LIMIT  = 2_000_000;  // ns
  localparam int SETTLE_CYC = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_beat_t;

  typedef struct {
    verdict_e    verdict;
    logic [4:0]  payload_length;
    logic [15:0] received_crc;
  } frame_verdict_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = REG_EXPECTED_ADDRESS;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [4:0]  payload_length_o;
  logic [15:0] received_crc_o;

  meter_response_frame_checker #(
    .MAX_FRAME(FRAME_MAX)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .verdict_o       (verdict_o),
    .payload_length_o(payload_length_o),
    .received_crc_o  (received_crc_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // queues between stimulus, predictor and verdict monitor
  rx_beat_t       byte_queue[$];
  frame_verdict_t pending_verdicts[$];

  int mismatches = 0;
  int beats_taken = 0;
  int bytes_queued = 0;

  // predictor copy of the register settings
  logic [7:0] want_addr = 8'h00;
  logic       crc_skipped = 1'b0;

  // predictor copy of the frame state
  logic [15:0] frame_crc   = CRC_INIT;
  logic [5:0]  frame_len   = '0;
  logic [7:0]  lead_byte   = '0;
  logic [7:0]  status_byte = '0;
  logic [7:0]  tail_prev   = '0;
  logic [7:0]  tail_last   = '0;
  logic        overrun     = 1'b0;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    logic        lsb;
    acc = c ^ {8'h00, b};
    repeat (8) begin
      lsb = acc[0];
      acc = acc >> 1;
      if (lsb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // advances the frame state by one accepted byte, queues a verdict on frame end
  task automatic predict_verdict(input logic [7:0] b, input logic last);
    frame_verdict_t v;
    logic [15:0]    rcrc;
    logic [15:0]    calc;
    logic [5:0]     plen;
    // a byte reaches the crc only once two more bytes are behind it
    if (frame_len >= 2) begin
      frame_crc = crc_step(frame_crc, tail_prev);
    end
    if (frame_len == 0) begin
      lead_byte = b;
    end else if (frame_len == 1) begin
      status_byte = b;
    end
    tail_prev = tail_last;
    tail_last = b;
    if (frame_len < COUNT_LIMIT) begin
      frame_len = frame_len + 6'd1;
    end
    if (frame_len > FRAME_MAX) begin
      overrun = 1'b1;
    end
    if (last) begin
      rcrc = {tail_prev, tail_last};
      calc = {frame_crc[7:0], frame_crc[15:8]};
      plen = frame_len - HDR_BYTES;
      if (overrun) begin
        v = '{VERDICT_OVERLEN, 5'd0, rcrc};
      end else if (frame_len < MIN_FRAME) begin
        v = '{VERDICT_SHORT, 5'd0, 16'd0};
      end else begin
        v.payload_length = plen[4:0];
        v.received_crc   = rcrc;
        if (!crc_skipped && rcrc != calc) begin
          v.verdict = VERDICT_BAD_CRC;
        end else if (lead_byte != want_addr) begin
          v.verdict = VERDICT_BAD_ADDR;
        end else if (frame_len == MIN_FRAME && (status_byte[3:0] & STATUS_MASK) != 0) begin
          v.verdict = VERDICT_DEV_ERROR;
        end else begin
          v.verdict = VERDICT_OK;
        end
      end
      pending_verdicts = {pending_verdicts, v};
      frame_crc   = CRC_INIT;
      frame_len   = '0;
      lead_byte   = '0;
      status_byte = '0;
      tail_prev   = '0;
      tail_last   = '0;
      overrun     = 1'b0;
    end
  endtask

  // byte driver
  int gap_left = 0;
  int send_calm = 0;
  int send_roll;
  rx_beat_t beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= 8'h00;
      frame_end_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_verdict(rx_byte_i, frame_end_i);
        beats_taken <= beats_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          beat = byte_queue.pop_front();
          in_valid_i  <= 1'b1;
          rx_byte_i   <= beat.rx_byte;
          frame_end_i <= beat.frame_end;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_roll = $urandom_range(0, 99);
            if (send_roll < 55) begin
              gap_left = 0;
            end else if (send_roll < 60) begin
              send_calm = $urandom_range(20, 80);
            end else if (send_roll < 92) begin
              gap_left = $urandom_range(1, 3);
            end else begin
              gap_left = $urandom_range(8, 30);
            end
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // verdict receiver: random stalls plus two long hold-offs
  int stall_left = 0;
  int ready_calm = 0;
  int long_holds = 0;
  int ready_roll;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (long_holds < 2 && beats_taken >= (long_holds == 0 ? 60 : 400)) begin
      // the sender keeps offering bytes, so the block backs up onto its input
      long_holds++;
      stall_left = 300;
      out_ready_i <= 1'b0;
    end else if (ready_calm > 0) begin
      ready_calm--;
      out_ready_i <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_ready_i <= 1'b1;
      end else if (ready_roll < 66) begin
        ready_calm = $urandom_range(20, 80);
        out_ready_i <= 1'b1;
      end else if (ready_roll < 95) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  // verdict monitor
  frame_verdict_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict beat %0d with no frame pending", verdict_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_o !== want.verdict) begin
          flag_mismatch($sformatf("verdict got %0d want %0d", verdict_o, want.verdict));
        end
        if (payload_length_o !== want.payload_length) begin
          flag_mismatch($sformatf("payload_length got %0d want %0d",
                                  payload_length_o, want.payload_length));
        end
        if (received_crc_o !== want.received_crc) begin
          flag_mismatch($sformatf("received_crc got %h want %h",
                                  received_crc_o, want.received_crc));
        end
      end
    end
  end

  // builds one frame; crc bytes go low byte first, as on the wire
  task automatic queue_frame(input int len, input logic [7:0] addr, input logic [7:0] status,
                             input bit crc_good);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          k;
    rx_beat_t    nb;
    body = {};
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        body = {body, addr};
      end else if (i == 1) begin
        body = {body, status};
      end else begin
        body = {body, 8'($urandom_range(0, 255))};
      end
    end
    if (len >= 4) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
        crc = crc_step(crc, body[i]);
      end
      body[len-2] = crc[7:0];
      body[len-1] = crc[15:8];
      if (!crc_good) begin
        k = len - 1 - $urandom_range(0, 1);
        body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) begin
      nb.rx_byte   = body[i];
      nb.frame_end = (i == len - 1);
      byte_queue   = {byte_queue, nb};
    end
    bytes_queued += len;
  endtask

  task automatic queue_random_frame();
    int         kind;
    int         len;
    logic [7:0] status;
    kind   = $urandom_range(0, 99);
    len    = ($urandom_range(0, 3) == 0) ? $urandom_range(4, FRAME_MAX) : $urandom_range(4, 10);
    status = 8'($urandom_range(0, 255));
    if (len == 4 && $urandom_range(0, 3) != 0) begin
      status[3:0] = 4'h0;
    end
    if (kind < 68) begin
      queue_frame(len, want_addr, status, 1'b1);
    end else if (kind < 76) begin
      queue_frame(len, want_addr, status, 1'b0);
    end else if (kind < 84) begin
      queue_frame(len, want_addr ^ 8'($urandom_range(1, 255)), status, 1'($urandom_range(0, 1)));
    end else if (kind < 92) begin
      queue_frame($urandom_range(1, 3), want_addr, status, 1'b1);
    end else if (kind < 95) begin
      // four-byte status frame with the error nibble set
      queue_frame(4, want_addr, {4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))}, 1'b1);
    end else begin
      queue_frame($urandom_range(FRAME_MAX + 1, FRAME_MAX + 40), want_addr, status,
                  1'($urandom_range(0, 1)));
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_EXPECTED_ADDRESS) begin
      want_addr = val;
    end else begin
      crc_skipped = val[0];
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (byte_queue.size() != 0 || in_valid_i || pending_verdicts.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = bytes_queued + count;
    @(negedge clk_i);
    while (bytes_queued < stop_at) begin
      queue_random_frame();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_EXPECTED_ADDRESS, 8'h00);
    write_reg(REG_SKIP_CRC_CHECK, 8'h00);

    // directed frames
    @(negedge clk_i);
    queue_frame(1, 8'h00, 8'h00, 1'b1);
    queue_frame(3, 8'hFF, 8'hFF, 1'b1);
    queue_frame(4, 8'h00, 8'h00, 1'b1);
    queue_frame(4, 8'h00, 8'h0F, 1'b1);
    queue_frame(4, 8'h00, 8'hF0, 1'b1);
    queue_frame(5, 8'h00, 8'h03, 1'b0);
    queue_frame(5, 8'hFF, 8'h03, 1'b1);
    wait_drained();

    write_reg(REG_EXPECTED_ADDRESS, 8'hFF);
    @(negedge clk_i);
    // saturates the byte counter
    queue_frame(70, 8'hFF, 8'h00, 1'b1);
    run_random(180);
    wait_drained();

    write_reg(REG_EXPECTED_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(REG_SKIP_CRC_CHECK, 8'h01);
    run_random(200);
    wait_drained();

    write_reg(REG_EXPECTED_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(REG_SKIP_CRC_CHECK, 8'h00);
    run_random(200);
    wait_drained();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[%0t] timeout, %0d verdicts still pending", $realtime, pending_verdicts.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
